// ----- sv/sync0_send_phase_lock_top_assert.svh -----
`ifndef SYNC0_SEND_PHASE_LOCK_TOP_ASSERT_SVH
`define SYNC0_SEND_PHASE_LOCK_TOP_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define SPL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/spl_pkg.sv -----
package spl_pkg;

    // default averaging depth
    localparam int unsigned PHASE_SAMPLES_DEF = 64;

    // cordic datapath
    localparam int CW           = 36;
    localparam int CORDIC_STEPS = 31;
    localparam int CORDIC_IW    = 5;
    localparam logic [CW-1:0] CORDIC_GAIN = 36'h026DD3B6A;
    localparam logic [31:0]   PI_Q30      = 32'd3373259426;
    localparam logic [32:0]   TWO_PI_Q30  = 33'd6746518852;
    localparam logic [63:0]   HALF_TWO_PI = 64'd3373259426;

    // serial divider widths
    localparam int DIV_NW = 64;
    localparam int DIV_DW = 33;
    localparam int DIV_CW = 6;

    // register indexes
    localparam logic [1:0] REG_DC_ENABLE = 2'd0;
    localparam logic [1:0] REG_INTERVAL  = 2'd1;
    localparam logic [1:0] REG_SHIFT     = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIFF,
        ST_SHIFT,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_ERR,
        ST_TURN_GO,
        ST_TURN_WAIT,
        ST_FOLD,
        ST_ZMUL,
        ST_ROT_GO,
        ST_ROT_WAIT,
        ST_MEANC_GO,
        ST_MEANC_WAIT,
        ST_MEANS_GO,
        ST_MEANS_WAIT,
        ST_COUNT,
        ST_VEC_GO,
        ST_VEC_WAIT,
        ST_AMUL,
        ST_AHI,
        ST_MERR_GO,
        ST_MERR_WAIT,
        ST_PWC,
        ST_PWS,
        ST_JUDGE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
        logic [DIV_DW-1:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic                 start;
        logic                 vec;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cor_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cor_rsp_t;

    // arctangent of 2^-i in q2.30
    function automatic logic [CW-1:0] atan_q30(input logic [CORDIC_IW-1:0] idx);
        logic [CW-1:0] v;
        case (idx)
            5'd0:    v = 36'h03243F6A8;
            5'd1:    v = 36'h01DAC6705;
            5'd2:    v = 36'h00FADBAFC;
            5'd3:    v = 36'h007F56EA6;
            5'd4:    v = 36'h003FEAB76;
            5'd5:    v = 36'h001FFD55B;
            5'd6:    v = 36'h000FFFAAA;
            5'd7:    v = 36'h0007FFF55;
            5'd8:    v = 36'h0003FFFEA;
            5'd9:    v = 36'h0001FFFFD;
            5'd10:   v = 36'h0000FFFFF;
            5'd11:   v = 36'h00007FFFF;
            5'd12:   v = 36'h00003FFFF;
            5'd13:   v = 36'h00001FFFF;
            5'd14:   v = 36'h00000FFFF;
            5'd15:   v = 36'h000007FFF;
            5'd16:   v = 36'h000003FFF;
            5'd17:   v = 36'h000001FFF;
            5'd18:   v = 36'h000000FFF;
            5'd19:   v = 36'h0000007FF;
            5'd20:   v = 36'h0000003FF;
            5'd21:   v = 36'h0000001FF;
            5'd22:   v = 36'h0000000FF;
            5'd23:   v = 36'h00000007F;
            5'd24:   v = 36'h00000003F;
            5'd25:   v = 36'h00000001F;
            5'd26:   v = 36'h00000000F;
            5'd27:   v = 36'h000000008;
            5'd28:   v = 36'h000000004;
            5'd29:   v = 36'h000000002;
            5'd30:   v = 36'h000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/spl_div.sv -----
module spl_div (
    input  logic              clk,
    input  logic              rst_n,
    input  spl_pkg::div_req_t req,
    output spl_pkg::div_rsp_t rsp
);

    logic                       busy_reg;
    logic                       done_reg;
    logic [spl_pkg::DIV_CW-1:0] cnt_reg;
    logic [spl_pkg::DIV_DW:0]   rem_reg;
    logic [spl_pkg::DIV_NW-1:0] quo_reg;
    logic [spl_pkg::DIV_DW-1:0] den_reg;
    logic [spl_pkg::DIV_DW:0]   trial;
    logic                       ge;
    logic [spl_pkg::DIV_DW:0]   rem_next;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg[spl_pkg::DIV_DW-1:0], quo_reg[spl_pkg::DIV_NW-1]};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? (trial - {1'b0, den_reg}) : trial;
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == spl_pkg::DIV_CW'(spl_pkg::DIV_NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[spl_pkg::DIV_NW-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg[spl_pkg::DIV_DW-1:0];

endmodule

// ----- sv/spl_cordic.sv -----
module spl_cordic (
    input  logic              clk,
    input  logic              rst_n,
    input  spl_pkg::cor_req_t req,
    output spl_pkg::cor_rsp_t rsp
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [spl_pkg::CORDIC_IW-1:0]    cnt_reg;
    logic                             vec_reg;
    logic signed [spl_pkg::CW-1:0]    x_reg;
    logic signed [spl_pkg::CW-1:0]    y_reg;
    logic signed [spl_pkg::CW-1:0]    z_reg;
    logic signed [spl_pkg::CW-1:0]    xs;
    logic signed [spl_pkg::CW-1:0]    ys;
    logic signed [spl_pkg::CW-1:0]    at;
    logic signed [spl_pkg::CW-1:0]    x_next;
    logic signed [spl_pkg::CW-1:0]    y_next;
    logic signed [spl_pkg::CW-1:0]    z_next;
    logic                             d_pos;
    logic                             hold;

    // one micro-rotation; rotation follows z, vectoring drives y to zero
    always_comb
    begin
        xs    = x_reg >>> cnt_reg;
        ys    = y_reg >>> cnt_reg;
        at    = $signed(spl_pkg::atan_q30(cnt_reg));
        d_pos = vec_reg ? y_reg[spl_pkg::CW-1] : !z_reg[spl_pkg::CW-1];
        hold  = vec_reg && (y_reg == '0);
        if (hold)
        begin
            x_next = x_reg;
            y_next = y_reg;
            z_next = z_reg;
        end
        else if (d_pos)
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == spl_pkg::CORDIC_IW'(spl_pkg::CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // vector registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            vec_reg <= req.vec;
            x_reg   <= req.x;
            y_reg   <= req.y;
            z_reg   <= req.z;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.x    = x_reg;
    assign rsp.y    = y_reg;
    assign rsp.z    = z_reg;

endmodule

// ----- sv/sync0_send_phase_lock_top.sv -----
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   now_ns
// out       output     out_valid / out_ready app_time_ns, stepped, step_ns, step_total
// cfg       input      cfg_write             cfg_index, cfg_data
//
// one transaction at a time; the time per transaction depends on whether locking is idle,
// the mean is filling (the sample that seeds it skips the divider) or the lock decision
// runs, set by the 64-step serial divider (run up to five times) and the 31-step cordic
// reset clears all lock state, counters and configuration; no clearing pass
// a result waits in the output register while the next transaction is taken

`include "sync0_send_phase_lock_top_assert.svh"

module sync0_send_phase_lock_top #(
    parameter int unsigned PHASE_SAMPLES = spl_pkg::PHASE_SAMPLES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [63:0]        now_ns,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [63:0]        app_time_ns,
    output logic               stepped,
    output logic signed [31:0] step_ns,
    output logic [31:0]        step_total,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int CNT_W = $clog2(PHASE_SAMPLES + 1);
    localparam logic [CNT_W-1:0] N_CNT  = CNT_W'(PHASE_SAMPLES);
    localparam logic [63:0]      N_HALF = 64'(PHASE_SAMPLES / 2);
    localparam logic [32:0]      N_DEN  = 33'(PHASE_SAMPLES);
    localparam int CW = spl_pkg::CW;

    spl_pkg::state_t state_reg;
    spl_pkg::state_t state_next;

    // configuration
    logic        dc_en_reg;
    logic [31:0] interval_reg;
    logic [30:0] shift_reg;

    // lock state
    logic [63:0]        ref_reg;
    logic               ref_valid_reg;
    logic [63:0]        offset_reg;
    logic [CNT_W-1:0]   sample_cnt_reg;
    logic [CNT_W-1:0]   off_cnt_reg;
    logic signed [31:0] mean_c_reg;
    logic signed [31:0] mean_s_reg;
    logic [31:0]        last_step_reg;
    logic [31:0]        step_cnt_reg;
    logic               out_valid_reg;

    // working registers
    logic [63:0]          now_reg;
    logic [63:0]          acc_reg;
    logic signed [33:0]   err_reg;
    logic [31:0]          t_reg;
    logic                 neg_reg;
    logic                 flip_reg;
    logic [63:0]          mul_p_reg;
    logic [31:0]          c_reg;
    logic [31:0]          s_reg;
    logic signed [CW-1:0] ang_reg;
    logic [31:0]          merr_reg;
    logic                 stp_reg;

    // output registers
    logic [63:0] app_out_reg;
    logic        stepped_out_reg;
    logic [31:0] step_ns_out_reg;
    logic [31:0] step_total_out_reg;

    spl_pkg::div_req_t div_req;
    spl_pkg::div_rsp_t div_rsp;
    spl_pkg::cor_req_t cor_req;
    spl_pkg::cor_rsp_t cor_rsp;

    logic        lock_on;
    logic        out_load;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_prod;

    logic [30:0]          half;
    logic [29:0]          quarter;
    logic [63:0]          d_mag;
    logic [31:0]          r_val;
    logic signed [33:0]   half_s;
    logic signed [33:0]   e0;
    logic signed [33:0]   e1;
    logic [33:0]          err_mag;
    logic [31:0]          tu;
    logic signed [32:0]   t_s;
    logic signed [32:0]   t_f;
    logic                 t_fold;
    logic [32:0]          t_fmag;
    logic [63:0]          zr;
    logic signed [CW-1:0] z_rot;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] sy;
    logic                 sel_s;
    logic [31:0]          samp;
    logic [31:0]          mean_cur;
    logic signed [32:0]   mdiff;
    logic [32:0]          mdiff_mag;
    logic [31:0]          mean_upd;
    logic [31:0]          q32;
    logic signed [CW-1:0] mcx;
    logic signed [CW-1:0] msx;
    logic [31:0]          mc_mag;
    logic [31:0]          ms_mag;
    logic [CW-1:0]        ang_mag;
    logic [35:0]          hi_prod;
    logic [63:0]          app_val;
    logic [63:0]          pw;
    logic                 coherent;
    logic                 far;
    logic [CNT_W-1:0]     off_inc;

    spl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    spl_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cor_req),
        .rsp   (cor_rsp)
    );

    // shared multiplier
    assign mul_prod = mul_a * mul_b;

    // phase arithmetic around the shared units
    always_comb
    begin
        lock_on   = dc_en_reg && ref_valid_reg && (interval_reg != 32'd0);
        half      = interval_reg[31:1];
        quarter   = interval_reg[31:2];
        d_mag     = acc_reg[63] ? (~acc_reg + 64'd1) : acc_reg;
        r_val     = !neg_reg ? div_rsp.rem[31:0]
                  : ((div_rsp.rem[31:0] != 32'd0) ? (interval_reg - div_rsp.rem[31:0]) : 32'd0);
        half_s    = $signed({3'b000, half});
        e0        = err_reg - half_s;
        e1        = (e0 <= -half_s) ? (e0 + $signed({2'b00, interval_reg})) : e0;
        err_mag   = err_reg[33] ? (34'd0 - err_reg) : err_reg;
        tu        = neg_reg ? (32'd0 - div_rsp.quot[31:0]) : div_rsp.quot[31:0];
        t_s       = $signed({t_reg[31], t_reg});
        t_fold    = 1'b0;
        t_f       = t_s;
        if (t_s > 33'sd1073741824)
        begin
            t_f    = t_s - 33'sd2147483648;
            t_fold = 1'b1;
        end
        else if (t_s < -33'sd1073741824)
        begin
            t_f    = t_s + 33'sd2147483648;
            t_fold = 1'b1;
        end
        t_fmag    = t_f[32] ? (33'd0 - t_f) : t_f;
        zr        = (mul_p_reg + 64'h0000_0000_4000_0000) >> 31;
        z_rot     = neg_reg ? -$signed(zr[CW-1:0]) : $signed(zr[CW-1:0]);
        cx        = flip_reg ? -cor_rsp.x : cor_rsp.x;
        sy        = flip_reg ? -cor_rsp.y : cor_rsp.y;
        sel_s     = (state_reg == spl_pkg::ST_MEANS_GO) || (state_reg == spl_pkg::ST_MEANS_WAIT);
        samp      = sel_s ? s_reg : c_reg;
        mean_cur  = sel_s ? mean_s_reg : mean_c_reg;
        mdiff     = $signed({samp[31], samp}) - $signed({mean_cur[31], mean_cur});
        mdiff_mag = mdiff[32] ? (33'd0 - mdiff) : mdiff;
        q32       = div_rsp.quot[31:0];
        mean_upd  = neg_reg ? (mean_cur - q32) : (mean_cur + q32);
        mcx       = CW'(mean_c_reg);
        msx       = CW'(mean_s_reg);
        mc_mag    = mean_c_reg[31] ? (32'd0 - mean_c_reg) : mean_c_reg;
        ms_mag    = mean_s_reg[31] ? (32'd0 - mean_s_reg) : mean_s_reg;
        ang_mag   = ang_reg[CW-1] ? (CW'(0) - ang_reg) : ang_reg;
        hi_prod   = ang_mag[CW-1:32] * interval_reg;
        app_val   = now_reg + offset_reg;
        pw        = acc_reg + mul_p_reg;
        coherent  = (pw >= 64'h0400_0000_0000_0000);
        far       = (merr_reg > {2'b00, quarter});
        off_inc   = off_cnt_reg + 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spl_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = lock_on ? spl_pkg::ST_SUM : spl_pkg::ST_FINISH;
            end
            spl_pkg::ST_SUM:       state_next = spl_pkg::ST_DIFF;
            spl_pkg::ST_DIFF:      state_next = spl_pkg::ST_SHIFT;
            spl_pkg::ST_SHIFT:     state_next = spl_pkg::ST_MOD_GO;
            spl_pkg::ST_MOD_GO:    state_next = spl_pkg::ST_MOD_WAIT;
            spl_pkg::ST_MOD_WAIT:
                if (div_rsp.done) state_next = spl_pkg::ST_ERR;
            spl_pkg::ST_ERR:       state_next = spl_pkg::ST_TURN_GO;
            spl_pkg::ST_TURN_GO:   state_next = spl_pkg::ST_TURN_WAIT;
            spl_pkg::ST_TURN_WAIT:
                if (div_rsp.done) state_next = spl_pkg::ST_FOLD;
            spl_pkg::ST_FOLD:      state_next = spl_pkg::ST_ZMUL;
            spl_pkg::ST_ZMUL:      state_next = spl_pkg::ST_ROT_GO;
            spl_pkg::ST_ROT_GO:    state_next = spl_pkg::ST_ROT_WAIT;
            spl_pkg::ST_ROT_WAIT:
                if (cor_rsp.done) state_next = spl_pkg::ST_MEANC_GO;
            spl_pkg::ST_MEANC_GO:
                state_next = (sample_cnt_reg == '0) ? spl_pkg::ST_COUNT : spl_pkg::ST_MEANC_WAIT;
            spl_pkg::ST_MEANC_WAIT:
                if (div_rsp.done) state_next = spl_pkg::ST_MEANS_GO;
            spl_pkg::ST_MEANS_GO:  state_next = spl_pkg::ST_MEANS_WAIT;
            spl_pkg::ST_MEANS_WAIT:
                if (div_rsp.done) state_next = spl_pkg::ST_COUNT;
            spl_pkg::ST_COUNT:
                state_next = (sample_cnt_reg < N_CNT) ? spl_pkg::ST_FINISH : spl_pkg::ST_VEC_GO;
            spl_pkg::ST_VEC_GO:    state_next = spl_pkg::ST_VEC_WAIT;
            spl_pkg::ST_VEC_WAIT:
                if (cor_rsp.done) state_next = spl_pkg::ST_AMUL;
            spl_pkg::ST_AMUL:      state_next = spl_pkg::ST_AHI;
            spl_pkg::ST_AHI:       state_next = spl_pkg::ST_MERR_GO;
            spl_pkg::ST_MERR_GO:   state_next = spl_pkg::ST_MERR_WAIT;
            spl_pkg::ST_MERR_WAIT:
                if (div_rsp.done) state_next = spl_pkg::ST_PWC;
            spl_pkg::ST_PWC:       state_next = spl_pkg::ST_PWS;
            spl_pkg::ST_PWS:       state_next = spl_pkg::ST_JUDGE;
            spl_pkg::ST_JUDGE:     state_next = spl_pkg::ST_FINISH;
            spl_pkg::ST_FINISH:
                if (out_load) state_next = spl_pkg::ST_IDLE;
            default:               state_next = spl_pkg::ST_IDLE;
        endcase
    end

    // unit requests and handshake outputs
    always_comb
    begin
        in_ready      = (state_reg == spl_pkg::ST_IDLE);
        out_load      = (state_reg == spl_pkg::ST_FINISH) && (!out_valid_reg || out_ready);
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        cor_req.start = 1'b0;
        cor_req.vec   = 1'b0;
        cor_req.x     = '0;
        cor_req.y     = '0;
        cor_req.z     = '0;
        mul_a         = '0;
        mul_b         = '0;
        case (state_reg)
            spl_pkg::ST_MOD_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = d_mag;
                div_req.den   = {1'b0, interval_reg};
            end
            spl_pkg::ST_TURN_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = {err_mag[31:0], 32'd0} + {33'd0, half};
                div_req.den   = {1'b0, interval_reg};
            end
            spl_pkg::ST_MEANC_GO, spl_pkg::ST_MEANS_GO:
            begin
                div_req.start = (sample_cnt_reg != '0);
                div_req.num   = {31'd0, mdiff_mag} + N_HALF;
                div_req.den   = N_DEN;
            end
            spl_pkg::ST_MERR_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = acc_reg + spl_pkg::HALF_TWO_PI;
                div_req.den   = spl_pkg::TWO_PI_Q30;
            end
            spl_pkg::ST_ROT_GO:
            begin
                cor_req.start = 1'b1;
                cor_req.x     = $signed(spl_pkg::CORDIC_GAIN);
                cor_req.z     = z_rot;
            end
            spl_pkg::ST_VEC_GO:
            begin
                cor_req.start = 1'b1;
                cor_req.vec   = 1'b1;
                if (mean_c_reg[31])
                begin
                    cor_req.x = -mcx;
                    cor_req.y = -msx;
                    cor_req.z = mean_s_reg[31] ? -$signed(CW'(spl_pkg::PI_Q30))
                                               : $signed(CW'(spl_pkg::PI_Q30));
                end
                else
                begin
                    cor_req.x = mcx;
                    cor_req.y = msx;
                end
            end
            spl_pkg::ST_ZMUL:
            begin
                mul_a = t_reg;
                mul_b = spl_pkg::PI_Q30;
            end
            spl_pkg::ST_AMUL:
            begin
                mul_a = ang_mag[31:0];
                mul_b = interval_reg;
            end
            spl_pkg::ST_PWC:
            begin
                mul_a = mc_mag;
                mul_b = mc_mag;
            end
            spl_pkg::ST_PWS:
            begin
                mul_a = ms_mag;
                mul_b = ms_mag;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // control, configuration and lock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spl_pkg::ST_IDLE;
            dc_en_reg      <= 1'b0;
            interval_reg   <= '0;
            shift_reg      <= '0;
            ref_reg        <= '0;
            ref_valid_reg  <= 1'b0;
            offset_reg     <= '0;
            sample_cnt_reg <= '0;
            off_cnt_reg    <= '0;
            mean_c_reg     <= '0;
            mean_s_reg     <= '0;
            last_step_reg  <= '0;
            step_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // register writes
            if (cfg_write)
            begin
                case (cfg_index)
                    spl_pkg::REG_DC_ENABLE: dc_en_reg    <= cfg_data[0];
                    spl_pkg::REG_INTERVAL:  interval_reg <= cfg_data;
                    spl_pkg::REG_SHIFT:     shift_reg    <= cfg_data[30:0];
                    default:                dc_en_reg    <= dc_en_reg;
                endcase
            end

            // output transaction
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                spl_pkg::ST_MEANC_GO:
                begin
                    if (sample_cnt_reg == '0)
                    begin
                        mean_c_reg <= c_reg;
                        mean_s_reg <= s_reg;
                    end
                end
                spl_pkg::ST_MEANC_WAIT:
                    if (div_rsp.done) mean_c_reg <= mean_upd;
                spl_pkg::ST_MEANS_WAIT:
                    if (div_rsp.done) mean_s_reg <= mean_upd;
                spl_pkg::ST_COUNT:
                    if (sample_cnt_reg < N_CNT) sample_cnt_reg <= sample_cnt_reg + 1'b1;
                spl_pkg::ST_JUDGE:
                begin
                    if (!(coherent && far))
                        off_cnt_reg <= '0;
                    else if (off_inc < N_CNT)
                        off_cnt_reg <= off_inc;
                    else
                    begin
                        // step the offset by minus the mean error
                        offset_reg     <= neg_reg ? (offset_reg + {32'd0, merr_reg})
                                                  : (offset_reg - {32'd0, merr_reg});
                        last_step_reg  <= neg_reg ? merr_reg : (32'd0 - merr_reg);
                        step_cnt_reg   <= step_cnt_reg + 32'd1;
                        sample_cnt_reg <= '0;
                        off_cnt_reg    <= '0;
                    end
                end
                spl_pkg::ST_FINISH:
                begin
                    if (out_load && !ref_valid_reg)
                    begin
                        ref_reg       <= app_val;
                        ref_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    ref_valid_reg <= ref_valid_reg;
                end
            endcase
        end
    end

    // working and output registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            spl_pkg::ST_IDLE:
            begin
                now_reg <= now_ns;
                stp_reg <= 1'b0;
            end
            spl_pkg::ST_SUM:       acc_reg <= now_reg + offset_reg;
            spl_pkg::ST_DIFF:      acc_reg <= acc_reg - ref_reg;
            spl_pkg::ST_SHIFT:     acc_reg <= acc_reg - {33'd0, shift_reg};
            spl_pkg::ST_MOD_GO:    neg_reg <= acc_reg[63];
            spl_pkg::ST_MOD_WAIT:
                if (div_rsp.done) err_reg <= $signed({2'b00, r_val});
            spl_pkg::ST_ERR:       err_reg <= e1;
            spl_pkg::ST_TURN_GO:   neg_reg <= err_reg[33];
            spl_pkg::ST_TURN_WAIT:
                if (div_rsp.done) t_reg <= tu;
            spl_pkg::ST_FOLD:
            begin
                t_reg    <= t_fmag[31:0];
                neg_reg  <= t_f[32];
                flip_reg <= t_fold;
            end
            spl_pkg::ST_ZMUL:      mul_p_reg <= mul_prod;
            spl_pkg::ST_ROT_WAIT:
            begin
                if (cor_rsp.done)
                begin
                    c_reg <= cx[31:0];
                    s_reg <= sy[31:0];
                end
            end
            spl_pkg::ST_MEANC_GO, spl_pkg::ST_MEANS_GO:
                neg_reg <= mdiff[32];
            spl_pkg::ST_VEC_WAIT:
                if (cor_rsp.done) ang_reg <= cor_rsp.z;
            spl_pkg::ST_AMUL:
            begin
                mul_p_reg <= mul_prod;
                neg_reg   <= ang_reg[CW-1];
            end
            spl_pkg::ST_AHI:       acc_reg <= mul_p_reg + {hi_prod[31:0], 32'd0};
            spl_pkg::ST_MERR_WAIT:
                if (div_rsp.done) merr_reg <= div_rsp.quot[31:0];
            spl_pkg::ST_PWC:       mul_p_reg <= mul_prod;
            spl_pkg::ST_PWS:
            begin
                acc_reg   <= mul_p_reg;
                mul_p_reg <= mul_prod;
            end
            spl_pkg::ST_JUDGE:
                stp_reg <= coherent && far && !(off_inc < N_CNT);
            default:
            begin
                now_reg <= now_reg;
            end
        endcase

        // result register
        if (out_load)
        begin
            app_out_reg        <= app_val;
            stepped_out_reg    <= stp_reg;
            step_ns_out_reg    <= last_step_reg;
            step_total_out_reg <= step_cnt_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign app_time_ns = app_out_reg;
    assign stepped     = stepped_out_reg;
    assign step_ns     = $signed(step_ns_out_reg);
    assign step_total  = step_total_out_reg;

    `SPL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "input taken while a transaction is in progress")
    `SPL_ASSERT_SAME(a_div_done_waited, div_rsp.done,
        state_reg == spl_pkg::ST_MOD_WAIT || state_reg == spl_pkg::ST_TURN_WAIT
        || state_reg == spl_pkg::ST_MEANC_WAIT || state_reg == spl_pkg::ST_MEANS_WAIT
        || state_reg == spl_pkg::ST_MERR_WAIT,
        "divider finished with no sequencer waiting")
    `SPL_ASSERT_SAME(a_cordic_done_waited, cor_rsp.done,
        state_reg == spl_pkg::ST_ROT_WAIT || state_reg == spl_pkg::ST_VEC_WAIT,
        "cordic finished with no sequencer waiting")
    `SPL_ASSERT_SAME(a_counters_in_range, 1'b1,
        sample_cnt_reg <= N_CNT && off_cnt_reg < N_CNT,
        "phase counters out of range")

endmodule

// ----- test/tb_sync0_send_phase_lock_top.sv -----
timeunit 1ns;
timeprecision 1ps;

typedef struct {
    bit [63:0] app;
    bit        stepped;
    bit [31:0] step;
    bit [31:0] total;
} send_result_t;

// scoreboard: predicts the send-phase lock and holds the expected results
class phase_lock_board;
    localparam int unsigned SAMPLES = spl_pkg::PHASE_SAMPLES_DEF;

    bit          dc_en;
    bit [31:0]   interval;
    bit [30:0]   shift;
    bit [63:0]   ref_time;
    bit          ref_ok;
    bit [63:0]   offset;
    int unsigned samples;
    int unsigned off_count;
    int          mean_c;
    int          mean_s;
    bit [31:0]   last_step;
    bit [31:0]   steps;
    send_result_t expected[$];
    int          mismatches;
    longint      atan_tab[31];

    function new();
        atan_tab = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
            64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
            64'h00000001};
    endfunction

    function void set_reg(input bit [1:0] idx, input bit [31:0] val);
        if (idx == spl_pkg::REG_DC_ENABLE) dc_en = val[0];
        else if (idx == spl_pkg::REG_INTERVAL) interval = val;
        else if (idx == spl_pkg::REG_SHIFT) shift = val[30:0];
    endfunction

    function int pending();
        return expected.size();
    endfunction

    // rounded division, ties away from zero
    function longint round_half(input longint n, input longint unsigned d);
        longint unsigned m;
        longint q;
        m = (n < 0) ? -n : n;
        q = (m + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    // rotation cordic from a turn fraction to cos and sin in q2.30
    function void rotate(input bit [31:0] turn, output int c, output int s);
        longint t, x, y, z, xs, ys;
        bit flip;
        t = $signed(turn);
        flip = 0;
        x = 64'h26DD3B6A;
        y = 0;
        if (t > 64'sd1073741824) begin
            t -= 64'sd2147483648;
            flip = 1;
        end
        else if (t < -64'sd1073741824) begin
            t += 64'sd2147483648;
            flip = 1;
        end
        z = round_half(t * 64'sd3373259426, 64'd2147483648);
        for (int i = 0; i < 31; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= atan_tab[i];
            end
            else begin
                x += ys;
                y -= xs;
                z += atan_tab[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    // vectoring cordic, angle of the mean vector in q2.30
    function longint vector_angle(input longint yv, input longint xv);
        longint x, y, z, xs, ys;
        x = xv;
        y = yv;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 31; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys;
                y -= xs;
                z += atan_tab[i];
            end
            else if (y < 0) begin
                x -= ys;
                y += xs;
                z -= atan_tab[i];
            end
        end
        return z;
    endfunction

    // phase measurement, mean update and step decision
    function bit lock_step(input bit [63:0] now);
        bit [63:0] iv, d, r, mag, rm, pw;
        longint half, err, ang, merr, abs_err, mc, ms;
        bit [31:0] tu;
        int c, s;
        if (!dc_en || !ref_ok || interval == 0) return 0;
        iv = interval;
        d = now + offset - ref_time - shift;
        if (d[63]) begin
            rm = (~d + 1) % iv;
            r = (rm != 0) ? iv - rm : 0;
        end
        else r = d % iv;
        half = iv / 2;
        err = longint'(r) - half;
        if (err <= -half) err += iv;
        mag = (err < 0) ? -err : err;
        tu = ((mag << 32) + iv / 2) / iv;
        if (err < 0) tu = -tu;
        rotate(tu, c, s);
        if (samples == 0) begin
            mean_c = c;
            mean_s = s;
        end
        else begin
            mean_c = mean_c + round_half(longint'(c) - mean_c, SAMPLES);
            mean_s = mean_s + round_half(longint'(s) - mean_s, SAMPLES);
        end
        if (samples < SAMPLES) begin
            samples++;
            return 0;
        end
        ang = vector_angle(mean_s, mean_c);
        mag = ((ang < 0) ? -ang : ang) * iv;
        merr = (mag + 64'd3373259426) / 64'd6746518852;
        if (ang < 0) merr = -merr;
        mc = mean_c;
        ms = mean_s;
        pw = mc * mc + ms * ms;
        abs_err = (merr < 0) ? -merr : merr;
        if (pw < 64'h0400_0000_0000_0000 || abs_err <= half / 2) begin
            off_count = 0;
            return 0;
        end
        off_count++;
        if (off_count < SAMPLES) return 0;
        offset -= merr;
        last_step = -merr;
        steps++;
        samples = 0;
        off_count = 0;
        return 1;
    endfunction

    function void note_stamp(input bit [63:0] now);
        send_result_t r;
        r.stepped = lock_step(now);
        r.app = now + offset;
        if (!ref_ok) begin
            ref_time = r.app;
            ref_ok = 1;
        end
        r.step = last_step;
        r.total = steps;
        expected.insert(expected.size(), r);
    endfunction

    function void mismatch(input string what, input bit [63:0] exp_v, input bit [63:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h actual %h", what, exp_v, act_v);
    endfunction

    function void check_result(input send_result_t got);
        send_result_t w;
        if (expected.size() == 0) begin
            mismatch("unexpected transaction", 0, got.app);
            return;
        end
        w = expected.pop_front();
        if (w.app != got.app) mismatch("app_time_ns", w.app, got.app);
        if (w.stepped != got.stepped) mismatch("stepped", w.stepped, got.stepped);
        if (w.step != got.step) mismatch("step_ns", w.step, got.step);
        if (w.total != got.total) mismatch("step_total", w.total, got.total);
    endfunction
endclass

module tb_sync0_send_phase_lock_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 400;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [63:0]        now_ns;
    logic               out_valid;
    logic               out_ready;
    logic [63:0]        app_time_ns;
    logic               stepped;
    logic signed [31:0] step_ns;
    logic [31:0]        step_total;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    phase_lock_board board = new();
    bit idle_on = 1;
    bit hold_req = 0;

    sync0_send_phase_lock_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .now_ns(now_ns),
        .out_valid(out_valid), .out_ready(out_ready), .app_time_ns(app_time_ns),
        .stepped(stepped), .step_ns(step_ns), .step_total(step_total),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("tb_sync0_send_phase_lock_top: FAIL");
        $finish;
    end

    // result transaction check
    always @(posedge clk)
    begin
        send_result_t got;
        if (rst_n && out_valid && out_ready) begin
            got.app = app_time_ns;
            got.stepped = stepped;
            got.step = step_ns;
            got.total = step_total;
            board.check_result(got);
        end
    end

    // receiver with random stalls and one long hold-off
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else out_ready <= 1'b1;
        end
    end

    // one input transaction, sometimes with a random gap in front
    task automatic send_stamp(input bit [63:0] v);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        now_ns <= v;
        do @(posedge clk); while (!in_ready);
        board.note_stamp(v);
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
    endtask

    // register write once every result is back
    task automatic write_reg(input bit [1:0] idx, input bit [31:0] val);
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic set_lock(input bit en, input bit [31:0] iv, input bit [31:0] sh);
        write_reg(spl_pkg::REG_DC_ENABLE, {31'b0, en});
        write_reg(spl_pkg::REG_INTERVAL, iv);
        write_reg(spl_pkg::REG_SHIFT, sh);
    endtask

    // cycle-aligned stamps with a send phase held for a while, plus some noise
    task automatic run_lock(input int n, input int per_phase);
        bit [63:0] base, v;
        bit [31:0] iv, phase, jit;
        iv = board.interval;
        base = {16'b0, $urandom, 16'b0} + {$urandom, $urandom} % 64'h1_0000_0000_0000;
        phase = 0;
        for (int k = 0; k < n; k++) begin
            if (k % per_phase == 0) phase = (iv > 1) ? $urandom_range(0, iv - 1) : 0;
            jit = (iv >= 16) ? $urandom_range(0, iv / 16) : 0;
            if ($urandom_range(0, 19) == 0) v = {$urandom, $urandom};
            else v = base + 64'(k) * iv + phase + jit;
            send_stamp(v);
        end
        end_burst();
    endtask

    initial
    begin
        bit [31:0] iv;
        in_valid = 1'b0;
        now_ns = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // locking idle after reset: stamp extremes, first one sets the reference
        send_stamp(64'h0);
        send_stamp(64'hFFFF_FFFF_FFFF_FFFF);
        send_stamp(64'h8000_0000_0000_0000);
        send_stamp(64'h5555_5555_5555_5555);
        send_stamp(64'hAAAA_AAAA_AAAA_AAAA);
        send_stamp({$urandom, $urandom});
        end_burst();

        // ignored index and masked shift
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        write_reg(spl_pkg::REG_SHIFT, 32'hFFFF_FFFF);

        // interval zero with dc enabled: no lock
        set_lock(1'b1, 32'd0, 32'd500);
        for (int k = 0; k < 6; k++) send_stamp({$urandom, $urandom});
        end_burst();

        // nominal cycle, steps expected
        set_lock(1'b1, 32'd1000, 32'd500);
        run_lock(300, 150);

        // largest interval and shift
        set_lock(1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        run_lock(300, 150);

        // smallest intervals
        set_lock(1'b1, 32'd1, 32'd0);
        run_lock(40, 40);
        set_lock(1'b1, 32'd2, 32'd1);
        run_lock(40, 40);

        // locking off, receiver holds off so the block fills and stalls its input
        set_lock(1'b0, 32'd5000, 32'd2500);
        hold_req = 1;
        for (int k = 0; k < 250; k++) send_stamp({$urandom, $urandom});
        end_burst();

        // random settings, the last one without idling
        for (int p = 0; p < 4; p++) begin
            iv = $urandom_range(3, 200000);
            set_lock(1'b1, iv, $urandom_range(0, iv));
            if (p == 3) idle_on = 0;
            run_lock(250, 125);
        end

        while (board.pending() != 0) @(posedge clk);
        repeat (500) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb_sync0_send_phase_lock_top: PASS");
        else
            $display("tb_sync0_send_phase_lock_top: FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+sv
sv/spl_pkg.sv
sv/spl_div.sv
sv/spl_cordic.sv
sv/sync0_send_phase_lock_top.sv
test/tb_sync0_send_phase_lock_top.sv
